// ===== design/cid_pkg.sv =====
// Shared codes and the decoded item type for the instruction decoder.
package cid_pkg;

    localparam int unsigned WORD_W = 16;

    // Format classes
    localparam logic [3:0] FMT_UNDEF = 4'd0;
    localparam logic [3:0] FMT_NR    = 4'd1;
    localparam logic [3:0] FMT_R     = 4'd2;
    localparam logic [3:0] FMT_RR    = 4'd3;
    localparam logic [3:0] FMT_RI5   = 4'd4;
    localparam logic [3:0] FMT_RRI5  = 4'd5;
    localparam logic [3:0] FMT_I8    = 4'd6;
    localparam logic [3:0] FMT_RI8   = 4'd7;
    localparam logic [3:0] FMT_I12   = 4'd8;

    // Operation classes
    localparam logic [2:0] CL_ALUR    = 3'd0;
    localparam logic [2:0] CL_BRANCH  = 3'd1;
    localparam logic [2:0] CL_CONTROL = 3'd2;
    localparam logic [2:0] CL_ENV     = 3'd3;
    localparam logic [2:0] CL_MEM     = 3'd4;
    localparam logic [2:0] CL_ALUI    = 3'd5;

    // Return-address register number
    localparam logic [3:0] RET_REG = 4'd8;

    // Function codes
    localparam logic [6:0] FN_UNKNOWN = 7'd0;
    localparam logic [6:0] FN_NOP     = 7'd1;
    localparam logic [6:0] FN_CLRT    = 7'd2;
    localparam logic [6:0] FN_SETT    = 7'd3;
    localparam logic [6:0] FN_NOTT    = 7'd4;
    localparam logic [6:0] FN_RTS     = 7'd5;
    localparam logic [6:0] FN_RTE     = 7'd6;
    localparam logic [6:0] FN_INTC    = 7'd7;
    localparam logic [6:0] FN_INTS    = 7'd8;
    localparam logic [6:0] FN_EBREAK  = 7'd9;
    localparam logic [6:0] FN_EXIT    = 7'd10;
    localparam logic [6:0] FN_MOVT    = 7'd11;
    localparam logic [6:0] FN_DT      = 7'd12;
    localparam logic [6:0] FN_BRAF    = 7'd13;
    localparam logic [6:0] FN_BSRF    = 7'd14;
    localparam logic [6:0] FN_JMP     = 7'd15;
    localparam logic [6:0] FN_JSR     = 7'd16;
    localparam logic [6:0] FN_SGZ     = 7'd17;
    localparam logic [6:0] FN_SGZU    = 7'd18;
    localparam logic [6:0] FN_MOV     = 7'd19;
    localparam logic [6:0] FN_LDB     = 7'd20;
    localparam logic [6:0] FN_LDW     = 7'd21;
    localparam logic [6:0] FN_STB     = 7'd22;
    localparam logic [6:0] FN_STW     = 7'd23;
    localparam logic [6:0] FN_ADD     = 7'd24;
    localparam logic [6:0] FN_ADDC    = 7'd25;
    localparam logic [6:0] FN_ADDV    = 7'd26;
    localparam logic [6:0] FN_SUB     = 7'd27;
    localparam logic [6:0] FN_SUBC    = 7'd28;
    localparam logic [6:0] FN_SUBV    = 7'd29;
    localparam logic [6:0] FN_AND     = 7'd30;
    localparam logic [6:0] FN_TST     = 7'd31;
    localparam logic [6:0] FN_NEG     = 7'd32;
    localparam logic [6:0] FN_NEGC    = 7'd33;
    localparam logic [6:0] FN_NOT     = 7'd34;
    localparam logic [6:0] FN_OR      = 7'd35;
    localparam logic [6:0] FN_XOR     = 7'd36;
    localparam logic [6:0] FN_SEQ     = 7'd37;
    localparam logic [6:0] FN_SGE     = 7'd38;
    localparam logic [6:0] FN_SGEU    = 7'd39;
    localparam logic [6:0] FN_SGT     = 7'd40;
    localparam logic [6:0] FN_SGTU    = 7'd41;
    localparam logic [6:0] FN_EXTS    = 7'd42;
    localparam logic [6:0] FN_EXTU    = 7'd43;
    localparam logic [6:0] FN_SLL     = 7'd44;
    localparam logic [6:0] FN_SRL     = 7'd45;
    localparam logic [6:0] FN_SRA     = 7'd46;
    localparam logic [6:0] FN_ROT     = 7'd47;
    localparam logic [6:0] FN_MULB    = 7'd48;
    localparam logic [6:0] FN_MULW    = 7'd49;
    localparam logic [6:0] FN_DIVB    = 7'd50;
    localparam logic [6:0] FN_DIVW    = 7'd51;
    localparam logic [6:0] FN_MULUB   = 7'd52;
    localparam logic [6:0] FN_MULUW   = 7'd53;
    localparam logic [6:0] FN_DIVUB   = 7'd54;
    localparam logic [6:0] FN_DIVUW   = 7'd55;
    localparam logic [6:0] FN_MODB    = 7'd56;
    localparam logic [6:0] FN_MODW    = 7'd57;
    localparam logic [6:0] FN_BCLR    = 7'd58;
    localparam logic [6:0] FN_BSET    = 7'd59;
    localparam logic [6:0] FN_BNOT    = 7'd60;
    localparam logic [6:0] FN_BTST    = 7'd61;
    localparam logic [6:0] FN_BF      = 7'd62;
    localparam logic [6:0] FN_BT      = 7'd63;
    localparam logic [6:0] FN_BRA     = 7'd64;
    localparam logic [6:0] FN_BSR     = 7'd65;

    // Decoded item, last field in the lowest bits
    typedef struct packed {
        logic        illegal;
        logic        writes_back;
        logic [15:0] immediate;
        logic [3:0]  src2_reg;
        logic [3:0]  src1_reg;
        logic [3:0]  dest_reg;
        logic [6:0]  func_code;
        logic [2:0]  op_class;
        logic [3:0]  format_class;
        logic [3:0]  major_opcode;
    } cid_result_t;

endpackage

// ===== design/cid_decode.sv =====
// Combinational decode of one instruction word into its fields.
module cid_decode
(
    input  logic [cid_pkg::WORD_W-1:0] word,
    output cid_pkg::cid_result_t       result
);
    import cid_pkg::*;

    logic [3:0]  op;
    logic [2:0]  m;
    logic [2:0]  n;
    logic        f1;
    logic        s7;
    logic [3:0]  f4;
    logic [5:0]  f6;
    logic [3:0]  sub8;
    logic [15:0] imm5;
    logic [15:0] imm8z;
    logic [15:0] imm8s;
    logic [15:0] imm12;
    logic [3:0]  dm;
    logic [3:0]  am;
    logic [3:0]  an;

    logic [3:0]  form;
    logic [2:0]  cls;
    logic [6:0]  fn;
    logic [3:0]  rd;
    logic [3:0]  rs1;
    logic [3:0]  rs2;
    logic [15:0] imm;
    logic        wb;
    logic        bad;

    assign op    = word[15:12];
    assign m     = word[10:8];
    assign n     = word[6:4];
    assign f1    = word[11];
    assign s7    = word[7];
    assign f4    = {f1, n};
    assign f6    = {f1, s7, word[3:0]};
    assign sub8  = {f1, m};
    assign imm5  = {{12{s7}}, word[3:0]};
    assign imm8z = {8'h00, word[7:0]};
    assign imm8s = {{8{s7}}, word[7:0]};
    assign imm12 = {{4{f1}}, word[11:0]};
    assign dm    = {1'b0, m};
    assign am    = {1'b1, m};
    assign an    = {1'b1, n};

    always_comb
    begin
        form = FMT_UNDEF;
        cls  = CL_ALUR;
        fn   = FN_UNKNOWN;
        rd   = dm;
        rs1  = dm;
        rs2  = {1'b0, n};
        imm  = 16'h0000;
        wb   = 1'b0;

        unique case (op)
            4'd0:
            begin
                form = FMT_NR;
                unique case (f6)
                    6'd0: fn = FN_NOP;
                    6'd1: fn = FN_CLRT;
                    6'd2: fn = FN_SETT;
                    6'd3: fn = FN_NOTT;
                    6'd4: begin cls = CL_BRANCH; fn = FN_RTS; rs1 = RET_REG; end
                    6'd5: begin cls = CL_BRANCH; fn = FN_RTE; end
                    6'd6: begin cls = CL_CONTROL; fn = FN_INTC; end
                    6'd7: begin cls = CL_CONTROL; fn = FN_INTS; end
                    6'd8: begin cls = CL_ENV; fn = FN_EBREAK; end
                    6'd9: begin cls = CL_ENV; fn = FN_EXIT; end
                    default: fn = FN_UNKNOWN;
                endcase
            end
            4'd1:
            begin
                form = FMT_R;
                unique case (f6)
                    6'd0: begin fn = FN_MOVT; wb = 1'b1; end
                    6'd1: begin fn = FN_DT; wb = 1'b1; end
                    6'd2: begin fn = FN_DT; rs1 = am; rd = am; wb = 1'b1; end
                    6'd3: begin cls = CL_BRANCH; fn = FN_BRAF; rs1 = am; end
                    6'd4:
                    begin
                        cls = CL_BRANCH; fn = FN_BSRF; rs1 = am; rd = RET_REG; wb = 1'b1;
                    end
                    6'd5: begin cls = CL_BRANCH; fn = FN_JMP; rs1 = am; end
                    6'd6:
                    begin
                        cls = CL_BRANCH; fn = FN_JSR; rs1 = am; rd = RET_REG; wb = 1'b1;
                    end
                    6'd7: fn = FN_SGZ;
                    6'd8: fn = FN_SGZU;
                    default: fn = FN_UNKNOWN;
                endcase
            end
            4'd2:
            begin
                form = FMT_RR;
                wb   = 1'b1;
                unique case (f6)
                    6'd0:  fn = FN_MOV;
                    6'd1:  begin fn = FN_MOV; rd = am; end
                    6'd2:  begin fn = FN_MOV; rs2 = an; rd = am; end
                    6'd3:  begin fn = FN_MOV; rs2 = an; end
                    6'd4:  begin cls = CL_MEM; fn = FN_LDB; rs2 = an; end
                    6'd5:  begin cls = CL_MEM; fn = FN_LDW; rs2 = an; end
                    6'd7:  begin cls = CL_MEM; fn = FN_STB; rs1 = am; wb = 1'b0; end
                    6'd8:  begin cls = CL_MEM; fn = FN_STW; rs1 = am; wb = 1'b0; end
                    6'd10: fn = FN_ADD;
                    6'd11: fn = FN_ADDC;
                    6'd12: fn = FN_ADDV;
                    6'd13: begin fn = FN_ADD; rs1 = am; rs2 = an; rd = am; end
                    6'd14: begin fn = FN_ADD; rs1 = am; rd = am; end
                    6'd15: fn = FN_SUB;
                    6'd16: fn = FN_SUBC;
                    6'd17: fn = FN_SUBV;
                    6'd18: begin fn = FN_SUB; rs1 = am; rs2 = an; rd = am; end
                    6'd19: begin fn = FN_SUB; rs1 = am; rd = am; end
                    6'd20: fn = FN_AND;
                    6'd21: begin fn = FN_TST; wb = 1'b0; end
                    6'd22: fn = FN_NEG;
                    6'd23: fn = FN_NEGC;
                    6'd24: fn = FN_NOT;
                    6'd25: fn = FN_OR;
                    6'd26: fn = FN_XOR;
                    6'd27: begin fn = FN_SEQ; wb = 1'b0; end
                    6'd28: begin fn = FN_SGE; wb = 1'b0; end
                    6'd29: begin fn = FN_SGEU; wb = 1'b0; end
                    6'd30: begin fn = FN_SGT; wb = 1'b0; end
                    6'd31: begin fn = FN_SGTU; wb = 1'b0; end
                    6'd32: fn = FN_EXTS;
                    6'd34: fn = FN_EXTU;
                    6'd36: fn = FN_SLL;
                    6'd37: fn = FN_SRL;
                    6'd38: fn = FN_SRA;
                    6'd39: fn = FN_ROT;
                    6'd40: fn = FN_MULB;
                    6'd41: fn = FN_MULW;
                    6'd43: fn = FN_DIVB;
                    6'd44: fn = FN_DIVW;
                    6'd46: fn = FN_MULUB;
                    6'd47: fn = FN_MULUW;
                    6'd49: fn = FN_DIVUB;
                    6'd50: fn = FN_DIVUW;
                    6'd52: fn = FN_MODB;
                    6'd53: fn = FN_MODW;
                    default: fn = FN_UNKNOWN;
                endcase
            end
            4'd3:
            begin
                form = FMT_RI5;
                cls  = CL_ALUI;
                wb   = 1'b1;
                imm  = imm5;
                unique case (f4)
                    4'd0: fn = FN_BCLR;
                    4'd1: fn = FN_BSET;
                    4'd2: fn = FN_BNOT;
                    4'd3: begin fn = FN_BTST; wb = 1'b0; end
                    4'd4: fn = FN_SLL;
                    4'd5: fn = FN_SRL;
                    4'd6: fn = FN_SRA;
                    4'd7: fn = FN_ROT;
                    default: fn = FN_UNKNOWN;
                endcase
            end
            4'd4:
            begin
                form = FMT_RRI5;
                cls  = CL_MEM;
                imm  = imm5;
                rs2  = an;
                if (f1)
                begin
                    fn  = FN_STW;
                    rs1 = am;
                end
                else
                begin
                    fn = FN_LDW;
                    rd = am;
                    wb = 1'b1;
                end
            end
            4'd5, 4'd6:
            begin
                form = FMT_RRI5;
                cls  = CL_MEM;
                imm  = imm5;
                rs2  = an;
                if (f1)
                begin
                    fn = (op == 4'd5) ? FN_STB : FN_STW;
                end
                else
                begin
                    fn = (op == 4'd5) ? FN_LDB : FN_LDW;
                    wb = 1'b1;
                end
            end
            4'd8:
            begin
                form = FMT_I8;
                cls  = CL_ALUI;
                rs1  = 4'd0;
                rd   = 4'd0;
                wb   = 1'b1;
                imm  = imm8z;
                unique case (sub8)
                    4'd0:  fn = FN_AND;
                    4'd1:  fn = FN_OR;
                    4'd2:  fn = FN_XOR;
                    4'd3:  begin fn = FN_TST; wb = 1'b0; end
                    4'd4:  fn = FN_MULUW;
                    4'd5:  fn = FN_DIVUW;
                    4'd6:  fn = FN_MODW;
                    4'd8:  begin fn = FN_MULW; imm = imm8s; end
                    4'd9:  begin fn = FN_DIVW; imm = imm8s; end
                    4'd10: begin cls = CL_BRANCH; fn = FN_BF; imm = imm8s; wb = 1'b0; end
                    4'd11: begin cls = CL_BRANCH; fn = FN_BT; imm = imm8s; wb = 1'b0; end
                    default: fn = FN_UNKNOWN;
                endcase
            end
            4'd9, 4'd10:
            begin
                form = FMT_RI8;
                cls  = CL_MEM;
                imm  = imm8s;
                if (!f1)
                begin
                    fn = FN_LDW;
                    wb = 1'b1;
                    if (op == 4'd10)
                    begin
                        rd = am;
                    end
                end
            end
            4'd11:
            begin
                form = FMT_RI8;
                cls  = CL_ALUI;
                wb   = 1'b1;
                imm  = imm8s;
                fn   = FN_ADD;
                if (f1)
                begin
                    rd = am;
                end
            end
            4'd12:
            begin
                form = FMT_RI8;
                cls  = CL_ALUI;
                if (!f1)
                begin
                    fn  = FN_SEQ;
                    imm = imm8s;
                end
                else
                begin
                    fn  = FN_MOV;
                    imm = imm8z;
                    wb  = 1'b1;
                end
            end
            4'd14, 4'd15:
            begin
                form = FMT_I12;
                cls  = CL_BRANCH;
                imm  = imm12;
                if (op == 4'd14)
                begin
                    fn = FN_BRA;
                end
                else
                begin
                    fn = FN_BSR;
                    rd = RET_REG;
                    wb = 1'b1;
                end
            end
            default:
            begin
                // reserved opcodes keep the defaults and flag illegal
                form = FMT_UNDEF;
            end
        endcase
    end

    assign bad = (fn == FN_UNKNOWN);

    always_comb
    begin
        result.major_opcode = op;
        result.format_class = form;
        result.op_class     = cls;
        result.func_code    = fn;
        result.dest_reg     = rd;
        result.src1_reg     = rs1;
        result.src2_reg     = rs2;
        result.immediate    = imm;
        result.writes_back  = wb & ~bad;
        result.illegal      = bad;
    end

endmodule

// ===== design/custom_isa_instruction_decoder.sv =====
// Top level of the instruction decoder: input register, decode and result register.
//
// Usage
//   Slave channel (s_axis_*) takes one 16-bit instruction word per item.
//   Master channel (m_axis_*) gives one decoded item per input item, in order.
//   Items move on a rising edge where tvalid and tready are both high.
// Pipeline and throughput
//   An accepted word is held in the input register, decoded by short
//   combinational logic and captured in the result register, from which the
//   decoded item is offered on m_axis. One item per clock is sustained
//   while m_axis_tready stays high; the two-register pipeline sets this.
// Reset
//   rst_n low clears both valid flags at once; no item is held afterwards.
// Stall
//   While the receiver holds m_axis_tready low the result register holds
//   its item; the input register still accepts one further word, so
//   s_axis_tready drops only when both registers are full.
module custom_isa_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] instr_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] major_opcode, [7:4] format_class, [10:8] op_class, [17:11] func_code,
    // [21:18] dest_reg, [25:22] src1_reg, [29:26] src2_reg, [45:30] immediate,
    // [46] writes_back, [47] illegal
    output logic [47:0] m_axis_tdata
);
    import cid_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] in_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    cid_result_t out_item_reg;
    cid_result_t decoded;
    logic        out_load;
    logic        in_load;

    // Advance the result register when it is empty or being drained
    assign out_load      = ~out_valid_reg | m_axis_tready;
    // Take a new word when the input register is empty or moving on
    assign in_load       = ~in_valid_reg | out_load;
    assign s_axis_tready = in_load;

    cid_decode u_decode
    (
        .word   (in_word_reg),
        .result (decoded)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load only with a valid item, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_load && s_axis_tvalid)
        begin
            in_word_reg <= s_axis_tdata;
        end
        if (out_load && in_valid_reg)
        begin
            out_item_reg <= decoded;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the instruction decoder: stream driver, monitor and decode predictor.
`timescale 1ns / 1ps

module tb_top;

    import cid_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 6;
    localparam int DRAIN_WAIT  = 8;     // two-stage pipeline plus margin
    localparam int STALL_LIMIT = 2000;  // cycles with no item moved on either side
    localparam int PHASE_ITEMS = 150;

    // Major opcodes, bits 15..12 of the word
    localparam logic [3:0] OP_SYS     = 4'd0;
    localparam logic [3:0] OP_REG     = 4'd1;
    localparam logic [3:0] OP_REGREG  = 4'd2;
    localparam logic [3:0] OP_REGIMM  = 4'd3;
    localparam logic [3:0] OP_MEMA    = 4'd4;
    localparam logic [3:0] OP_MEMB    = 4'd5;
    localparam logic [3:0] OP_MEMW    = 4'd6;
    localparam logic [3:0] OP_RSVD7   = 4'd7;
    localparam logic [3:0] OP_IMM8    = 4'd8;
    localparam logic [3:0] OP_LDD     = 4'd9;
    localparam logic [3:0] OP_LDA     = 4'd10;
    localparam logic [3:0] OP_ADDI    = 4'd11;
    localparam logic [3:0] OP_SEQMOV  = 4'd12;
    localparam logic [3:0] OP_RSVD13  = 4'd13;
    localparam logic [3:0] OP_BRA     = 4'd14;
    localparam logic [3:0] OP_BSR     = 4'd15;

    typedef struct {
        logic [15:0] word;
        cid_result_t dec;
    } decode_expect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;

    logic [15:0]    words_pending[$];
    decode_expect_t decodes_due[$];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          illegal_seen = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    logic [127:0] funcs_seen = '0;

    custom_isa_instruction_decoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // [15:0] instr_word
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        // [3:0] major_opcode, [7:4] format_class, [10:8] op_class, [17:11] func_code,
        // [21:18] dest_reg, [25:22] src1_reg, [29:26] src2_reg, [45:30] immediate,
        // [46] writes_back, [47] illegal
        .m_axis_tdata  (m_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Work out the decoded item for one instruction word.
    function automatic cid_result_t decode_word(input logic [15:0] w);
        cid_result_t r;
        logic [2:0]  m;
        logic [2:0]  n;
        logic        f1;
        logic        s7;
        logic [3:0]  f4;
        logic [5:0]  f6;
        logic [3:0]  am;
        logic [3:0]  an;
        logic [15:0] imm5;
        logic [15:0] imm8z;
        logic [15:0] imm8s;
        logic [15:0] imm12;
        logic        wb;
        m     = w[10:8];
        n     = w[6:4];
        f1    = w[11];
        s7    = w[7];
        f4    = {f1, n};
        f6    = {f1, s7, w[3:0]};
        am    = {1'b1, m};
        an    = {1'b1, n};
        imm5  = {{12{s7}}, w[3:0]};
        imm8z = {8'h00, w[7:0]};
        imm8s = {{8{s7}}, w[7:0]};
        imm12 = {{4{f1}}, w[11:0]};
        r = '0;
        r.major_opcode = w[15:12];
        r.format_class = FMT_UNDEF;
        r.op_class     = CL_ALUR;
        r.func_code    = FN_UNKNOWN;
        r.dest_reg     = {1'b0, m};
        r.src1_reg     = {1'b0, m};
        r.src2_reg     = {1'b0, n};
        r.immediate    = '0;
        wb = 1'b0;
        case (w[15:12])
            OP_SYS:
            begin
                r.format_class = FMT_NR;
                case (f6)
                    6'd0: r.func_code = FN_NOP;
                    6'd1: r.func_code = FN_CLRT;
                    6'd2: r.func_code = FN_SETT;
                    6'd3: r.func_code = FN_NOTT;
                    6'd4:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_RTS; r.src1_reg = RET_REG;
                    end
                    6'd5: begin r.op_class = CL_BRANCH;  r.func_code = FN_RTE;    end
                    6'd6: begin r.op_class = CL_CONTROL; r.func_code = FN_INTC;   end
                    6'd7: begin r.op_class = CL_CONTROL; r.func_code = FN_INTS;   end
                    6'd8: begin r.op_class = CL_ENV;     r.func_code = FN_EBREAK; end
                    6'd9: begin r.op_class = CL_ENV;     r.func_code = FN_EXIT;   end
                    default: ;
                endcase
            end
            OP_REG:
            begin
                r.format_class = FMT_R;
                case (f6)
                    6'd0: begin r.func_code = FN_MOVT; wb = 1'b1; end
                    6'd1: begin r.func_code = FN_DT;   wb = 1'b1; end
                    6'd2:
                    begin
                        r.func_code = FN_DT; r.src1_reg = am; r.dest_reg = am; wb = 1'b1;
                    end
                    6'd3:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_BRAF; r.src1_reg = am;
                    end
                    6'd4:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_BSRF; r.src1_reg = am;
                        r.dest_reg = RET_REG; wb = 1'b1;
                    end
                    6'd5:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_JMP; r.src1_reg = am;
                    end
                    6'd6:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_JSR; r.src1_reg = am;
                        r.dest_reg = RET_REG; wb = 1'b1;
                    end
                    6'd7: r.func_code = FN_SGZ;
                    6'd8: r.func_code = FN_SGZU;
                    default: ;
                endcase
            end
            OP_REGREG:
            begin
                r.format_class = FMT_RR;
                wb = 1'b1;
                case (f6)
                    6'd0:  r.func_code = FN_MOV;
                    6'd1:  begin r.func_code = FN_MOV; r.dest_reg = am; end
                    6'd2:  begin r.func_code = FN_MOV; r.src2_reg = an; r.dest_reg = am; end
                    6'd3:  begin r.func_code = FN_MOV; r.src2_reg = an; end
                    6'd4:  begin r.op_class = CL_MEM; r.func_code = FN_LDB; r.src2_reg = an; end
                    6'd5:  begin r.op_class = CL_MEM; r.func_code = FN_LDW; r.src2_reg = an; end
                    6'd7:
                    begin
                        r.op_class = CL_MEM; r.func_code = FN_STB; r.src1_reg = am; wb = 1'b0;
                    end
                    6'd8:
                    begin
                        r.op_class = CL_MEM; r.func_code = FN_STW; r.src1_reg = am; wb = 1'b0;
                    end
                    6'd10: r.func_code = FN_ADD;
                    6'd11: r.func_code = FN_ADDC;
                    6'd12: r.func_code = FN_ADDV;
                    6'd13:
                    begin
                        r.func_code = FN_ADD; r.src1_reg = am; r.src2_reg = an; r.dest_reg = am;
                    end
                    6'd14: begin r.func_code = FN_ADD; r.src1_reg = am; r.dest_reg = am; end
                    6'd15: r.func_code = FN_SUB;
                    6'd16: r.func_code = FN_SUBC;
                    6'd17: r.func_code = FN_SUBV;
                    6'd18:
                    begin
                        r.func_code = FN_SUB; r.src1_reg = am; r.src2_reg = an; r.dest_reg = am;
                    end
                    6'd19: begin r.func_code = FN_SUB; r.src1_reg = am; r.dest_reg = am; end
                    6'd20: r.func_code = FN_AND;
                    6'd21: begin r.func_code = FN_TST; wb = 1'b0; end
                    6'd22: r.func_code = FN_NEG;
                    6'd23: r.func_code = FN_NEGC;
                    6'd24: r.func_code = FN_NOT;
                    6'd25: r.func_code = FN_OR;
                    6'd26: r.func_code = FN_XOR;
                    6'd27: begin r.func_code = FN_SEQ;  wb = 1'b0; end
                    6'd28: begin r.func_code = FN_SGE;  wb = 1'b0; end
                    6'd29: begin r.func_code = FN_SGEU; wb = 1'b0; end
                    6'd30: begin r.func_code = FN_SGT;  wb = 1'b0; end
                    6'd31: begin r.func_code = FN_SGTU; wb = 1'b0; end
                    6'd32: r.func_code = FN_EXTS;
                    6'd34: r.func_code = FN_EXTU;
                    6'd36: r.func_code = FN_SLL;
                    6'd37: r.func_code = FN_SRL;
                    6'd38: r.func_code = FN_SRA;
                    6'd39: r.func_code = FN_ROT;
                    6'd40: r.func_code = FN_MULB;
                    6'd41: r.func_code = FN_MULW;
                    6'd43: r.func_code = FN_DIVB;
                    6'd44: r.func_code = FN_DIVW;
                    6'd46: r.func_code = FN_MULUB;
                    6'd47: r.func_code = FN_MULUW;
                    6'd49: r.func_code = FN_DIVUB;
                    6'd50: r.func_code = FN_DIVUW;
                    6'd52: r.func_code = FN_MODB;
                    6'd53: r.func_code = FN_MODW;
                    default: ;
                endcase
            end
            OP_REGIMM:
            begin
                r.format_class = FMT_RI5;
                r.op_class     = CL_ALUI;
                r.immediate    = imm5;
                wb = 1'b1;
                case (f4)
                    4'd0: r.func_code = FN_BCLR;
                    4'd1: r.func_code = FN_BSET;
                    4'd2: r.func_code = FN_BNOT;
                    4'd3: begin r.func_code = FN_BTST; wb = 1'b0; end
                    4'd4: r.func_code = FN_SLL;
                    4'd5: r.func_code = FN_SRL;
                    4'd6: r.func_code = FN_SRA;
                    4'd7: r.func_code = FN_ROT;
                    default: ;
                endcase
            end
            OP_MEMA:
            begin
                r.format_class = FMT_RRI5;
                r.op_class     = CL_MEM;
                r.immediate    = imm5;
                r.src2_reg     = an;
                if (f1)
                begin
                    r.func_code = FN_STW; r.src1_reg = am;
                end
                else
                begin
                    r.func_code = FN_LDW; r.dest_reg = am; wb = 1'b1;
                end
            end
            OP_MEMB, OP_MEMW:
            begin
                r.format_class = FMT_RRI5;
                r.op_class     = CL_MEM;
                r.immediate    = imm5;
                r.src2_reg     = an;
                if (f1)
                    r.func_code = (w[15:12] == OP_MEMB) ? FN_STB : FN_STW;
                else
                begin
                    r.func_code = (w[15:12] == OP_MEMB) ? FN_LDB : FN_LDW;
                    wb = 1'b1;
                end
            end
            OP_IMM8:
            begin
                // Subcodes 0..6 and the unassigned ones zero extend; 8..11 sign extend
                r.format_class = FMT_I8;
                r.op_class     = CL_ALUI;
                r.src1_reg     = 4'd0;
                r.dest_reg     = 4'd0;
                r.immediate    = imm8z;
                wb = 1'b1;
                case ({f1, m})
                    4'd0: r.func_code = FN_AND;
                    4'd1: r.func_code = FN_OR;
                    4'd2: r.func_code = FN_XOR;
                    4'd3: begin r.func_code = FN_TST; wb = 1'b0; end
                    4'd4: r.func_code = FN_MULUW;
                    4'd5: r.func_code = FN_DIVUW;
                    4'd6: r.func_code = FN_MODW;
                    4'd8: begin r.func_code = FN_MULW; r.immediate = imm8s; end
                    4'd9: begin r.func_code = FN_DIVW; r.immediate = imm8s; end
                    4'd10:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_BF;
                        r.immediate = imm8s; wb = 1'b0;
                    end
                    4'd11:
                    begin
                        r.op_class = CL_BRANCH; r.func_code = FN_BT;
                        r.immediate = imm8s; wb = 1'b0;
                    end
                    default: ;
                endcase
            end
            OP_LDD, OP_LDA:
            begin
                r.format_class = FMT_RI8;
                r.op_class     = CL_MEM;
                r.immediate    = imm8s;
                if (!f1)
                begin
                    r.func_code = FN_LDW;
                    wb = 1'b1;
                    if (w[15:12] == OP_LDA)
                        r.dest_reg = am;
                end
            end
            OP_ADDI:
            begin
                r.format_class = FMT_RI8;
                r.op_class     = CL_ALUI;
                r.immediate    = imm8s;
                r.func_code    = FN_ADD;
                wb = 1'b1;
                if (f1)
                    r.dest_reg = am;
            end
            OP_SEQMOV:
            begin
                r.format_class = FMT_RI8;
                r.op_class     = CL_ALUI;
                if (!f1)
                begin
                    r.func_code = FN_SEQ; r.immediate = imm8s;
                end
                else
                begin
                    r.func_code = FN_MOV; r.immediate = imm8z; wb = 1'b1;
                end
            end
            OP_BRA, OP_BSR:
            begin
                r.format_class = FMT_I12;
                r.op_class     = CL_BRANCH;
                r.immediate    = imm12;
                if (w[15:12] == OP_BRA)
                    r.func_code = FN_BRA;
                else
                begin
                    r.func_code = FN_BSR; r.dest_reg = RET_REG; wb = 1'b1;
                end
            end
            default: ;  // reserved opcodes keep the undefined defaults
        endcase
        r.illegal     = (r.func_code == FN_UNKNOWN);
        r.writes_back = wb && !r.illegal;
        return r;
    endfunction

    // Draw a word: mostly legal encodings, weighted towards the opcodes
    // with many subcodes, the rest raw noise including reserved opcodes.
    function automatic logic [15:0] random_word();
        logic [15:0] w;
        cid_result_t d;
        int          pick;
        bit          legal_only;
        legal_only = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        do
        begin
            w = 16'($urandom);
            if (pick < 30)
                w[15:12] = OP_REGREG;
            else if (pick < 38)
                w[15:12] = OP_SYS;
            else if (pick < 45)
                w[15:12] = OP_REG;
            d = decode_word(w);
        end
        while (legal_only && d.illegal);
        return w;
    endfunction

    task automatic check_field(input string name, input logic [15:0] word,
                               input logic [15:0] exp_val, input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: word %h field %s expected %h actual %h",
                     $time, word, name, exp_val, act_val);
            errors++;
        end
    endtask

    // Hold the control process until every queued word is sent and decoded.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (words_pending.size() != 0 || s_valid || decodes_due.size() != 0);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
        begin
            @(negedge clk);
            words_pending.push_back(random_word());
        end
    endtask

    // Driver: record each accepted word's decode, then load the next one or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_valid && s_ready)
            begin
                decode_expect_t e;
                e.word = s_data;
                e.dec  = decode_word(s_data);
                decodes_due.push_back(e);
                words_sent++;
            end
            // advance only when the slot is free or the current item has moved
            if (!s_valid || s_ready)
            begin
                if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_valid <= 1'b1;
                    s_data  <= words_pending.pop_front();
                end
                else
                    s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each decoded item against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                cid_result_t    got;
                decode_expect_t e;
                got = m_data;
                if (decodes_due.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none actual %h", $time, m_data);
                    errors++;
                end
                else
                begin
                    e = decodes_due.pop_front();
                    check_field("major_opcode", e.word, 16'(e.dec.major_opcode),
                                16'(got.major_opcode));
                    check_field("format_class", e.word, 16'(e.dec.format_class),
                                16'(got.format_class));
                    check_field("op_class",     e.word, 16'(e.dec.op_class),
                                16'(got.op_class));
                    check_field("func_code",    e.word, 16'(e.dec.func_code),
                                16'(got.func_code));
                    check_field("dest_reg",     e.word, 16'(e.dec.dest_reg),
                                16'(got.dest_reg));
                    check_field("src1_reg",     e.word, 16'(e.dec.src1_reg),
                                16'(got.src1_reg));
                    check_field("src2_reg",     e.word, 16'(e.dec.src2_reg),
                                16'(got.src2_reg));
                    check_field("immediate",    e.word, e.dec.immediate,    got.immediate);
                    check_field("writes_back",  e.word, 16'(e.dec.writes_back),
                                16'(got.writes_back));
                    check_field("illegal",      e.word, 16'(e.dec.illegal),
                                16'(got.illegal));
                    funcs_seen[e.dec.func_code] = 1'b1;
                    if (e.dec.illegal)
                        illegal_seen++;
                    results_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: drop the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [15:0] directed[$];
        directed = '{
            16'h0000,  // nop, all bits low
            16'hFFFF,  // bsr, all bits high, negative 12-bit offset
            16'h7ABC,  // reserved opcode 7
            16'hD123,  // reserved opcode 13
            16'h000A,  // unassigned system subcode
            16'h0004,  // rts reads the return-address register
            16'h0009,  // exit
            16'h1606,  // jsr writes the return-address register
            16'h1504,  // bsrf
            16'h2306,  // unassigned reg-reg subcode: write-back must be dropped
            16'h2FF5,  // modw, top subcode
            16'h215D,  // add on address registers
            16'h32BF,  // btst with negative 5-bit immediate
            16'h3815,  // unassigned bit-op subcode
            16'h4C8F,  // store word via address register, negative offset
            16'h6170,  // load word
            16'h80FF,  // immediate and: zero extended despite bit 7
            16'h8880,  // mulw: sign extended
            16'h8B9C,  // bt
            16'h87F0,  // unassigned subcode 7: zero extended
            16'h8CA5,  // unassigned subcode 12
            16'h9800,  // load with bit 11 set is unassigned
            16'hA37F,  // load to address register
            16'hBA81,  // add immediate to address register
            16'hC0FE,  // seq, sign extended
            16'hC8FE,  // mov immediate, zero extended
            16'hE800   // bra, most negative offset
        };

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (directed[i])
            words_pending.push_back(directed[i]);
        wait_quiet();

        // Phase 0: no idling on either side
        queue_random(PHASE_ITEMS);
        wait_quiet();

        // Phase 1: sender idle most cycles; pause half way until all decodes are back
        send_idle_pct  = 61;
        recv_stall_pct = 0;
        queue_random(PHASE_ITEMS / 2);
        wait_quiet();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_quiet();

        // Phase 2: receiver stalls most cycles
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        queue_random(PHASE_ITEMS);
        wait_quiet();

        // Phase 3: light idling on both sides
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random(PHASE_ITEMS);
        wait_quiet();

        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Decoded %0d words (%0d flagged illegal) under four idling patterns.",
                 results_checked, illegal_seen);
        $display("Function codes exercised: %0d of 65.", $countones(funcs_seen >> 1));
        if (errors == 0 && decodes_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
